// ===== rtl/msw_pkg.sv =====
// Shared constants for the moving-average hysteresis light switch.
// No dependencies; imported by every module of the block.
package msw_pkg;

    // Default parameter values
    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int THRESH_W   = 12;
    localparam int AVG_W      = 12;
    localparam int CFG_ADDR_W = 1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DARK  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT = 1'b1;

    // Threshold reset values
    localparam logic [THRESH_W-1:0] DARK_RESET  = 12'd3000;
    localparam logic [THRESH_W-1:0] LIGHT_RESET = 12'd3700;

endpackage

// ===== rtl/msw_ring.sv =====
// Sample ring memory: one write port, one synchronous (registered) read port.
// Depends on msw_pkg for defaults only.
module msw_ring #(
    parameter int WINDOW      = msw_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_data,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_data
);
    import msw_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [WINDOW];

    // Write the new sample into its slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/msw_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on msw_pkg for its import only.
module msw_divider #(
    parameter int DIVD_W = 16,
    parameter int DIVS_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);
    import msw_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(DIVD_W);
        end
        else if (step_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/moving_average_hysteresis_switch.sv =====
// Top level of the moving-average light switch with hysteresis.
// Depends on msw_pkg, msw_ring and msw_divider.
//
//  channel  | dir | tdata bits (low to high)                  | handshake
//  s_*      | in  | sample                                    | tvalid/tready
//  m_*      | out | average, lamp_on, lamp_changed            | tvalid/tready
//  cfg_*    | in  | register index cfg_addr, value cfg_data   | cfg_we, no wait
//
// A request runs in order: the ring read happens at the accept edge, then the
// sum update and ring write in ST_READ, the bit-serial divider in ST_DIV, then
// the output load. The next request is taken only in ST_IDLE after the load,
// so a request is not taken before the last one has been loaded.
// Most of each request is spent in the divider's one-bit-per-cycle loop.
// Reset clears the ring by fill count, so no clearing pass is needed.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the next result stalls only until the pending one is taken.
module moving_average_hysteresis_switch #(
    parameter int WINDOW      = msw_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF,
    parameter int S_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_DATA_W-1:0]             s_tdata,   // sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // average, lamp_on, lamp_changed
    input  logic                            cfg_we,
    input  logic [msw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [msw_pkg::THRESH_W-1:0]    cfg_data
);
    import msw_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int QEXT_W = (SUM_W > AVG_W) ? SUM_W : AVG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                  state_reg;
    logic [THRESH_W-1:0]     dark_reg;
    logic [THRESH_W-1:0]     light_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    lamp_reg, lamp_next;
    logic                    changed_next;
    logic                    m_tvalid_reg;
    logic [AVG_W-1:0]        avg_out_reg;
    logic                    lamp_out_reg;
    logic                    changed_out_reg;

    logic                    accept;
    logic                    start_div;
    logic [SAMPLE_BITS-1:0]  old_sample;
    logic                    div_done;
    logic [SUM_W-1:0]        quotient;
    logic [QEXT_W-1:0]       quo_ext;
    logic [AVG_W-1:0]        avg;
    logic                    out_free;
    logic                    load_out;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign start_div = (state_reg == ST_READ);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = ((state_reg == ST_DIV && div_done) || state_reg == ST_HOLD) && out_free;

    // Ring of the last WINDOW samples
    msw_ring #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_ring (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (old_sample),
        .wr_en   (start_div),
        .wr_addr (slot_reg),
        .wr_data (sample_reg)
    );

    // Remove the oldest sample once the ring is full, add the new one
    always_comb
    begin
        if (count_reg == CNT_W'(WINDOW))
        begin
            sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
            count_next = count_reg;
        end
        else
        begin
            sum_next   = sum_reg + SUM_W'(sample_reg);
            count_next = count_reg + 1'b1;
        end
        if (slot_reg == IDX_W'(WINDOW - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
    end

    // Divide the running sum by the fill count
    msw_divider #(
        .DIVD_W (SUM_W),
        .DIVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_div),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign quo_ext = QEXT_W'(quotient);
    assign avg     = quo_ext[AVG_W-1:0];

    // Apply the hysteresis rule chosen by the current flag
    always_comb
    begin
        lamp_next    = lamp_reg;
        changed_next = 1'b0;
        if (!lamp_reg)
        begin
            if (avg < dark_reg)
            begin
                lamp_next    = 1'b1;
                changed_next = 1'b1;
            end
        end
        else
        begin
            if (avg > light_reg)
            begin
                lamp_next    = 1'b0;
                changed_next = 1'b1;
            end
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg  <= DARK_RESET;
            light_reg <= LIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DARK:  dark_reg  <= cfg_data;
                REG_LIGHT: light_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Latch the accepted sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Sequence the request and hold the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sum_reg         <= '0;
            slot_reg        <= '0;
            count_reg       <= '0;
            lamp_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            avg_out_reg     <= '0;
            lamp_out_reg    <= 1'b0;
            changed_out_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a load, drop it once the result is taken
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    slot_reg  <= slot_next;
                    state_reg <= ST_DIV;
                end
                ST_DIV, ST_HOLD:
                begin
                    if (div_done || state_reg == ST_HOLD)
                    begin
                        if (out_free)
                        begin
                            avg_out_reg     <= avg;
                            lamp_out_reg    <= lamp_next;
                            changed_out_reg <= changed_next;
                            lamp_reg        <= lamp_next;
                            state_reg       <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, changed_out_reg, lamp_out_reg, avg_out_reg};

endmodule
